// File: rtl/core/izoc_pkg.sv
// shared widths, types and constants of the imu zero offset calibrator
`timescale 1ns / 1ps

package izoc_pkg;

    localparam int AXES      = 3;
    localparam int Z_AXIS    = 2;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int COUNT_W   = 8;
    localparam int ONE_G_W   = 15;

    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd4096;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [SAMPLE_W-1:0] t_mag;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef t_sample t_sample_arr [AXES];
    typedef t_mag    t_mag_arr    [AXES];
    typedef t_sum    t_sum_arr    [AXES];

    // per group flags that travel with a transaction down the pipeline
    typedef struct packed {
        logic clr;
        logic done;
        logic busy;
    } t_cal_status;

endpackage

// File: rtl/core/izoc_accum.sv
// stage one: calibration sequencer and running sums for one sensor group
`timescale 1ns / 1ps

module izoc_accum
    import izoc_pkg::*;
#(
    parameter int CAL_SAMPLES = 250
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_sample_arr i_sample,
    input  logic        i_start,
    output t_cal_status o_status,
    output t_sum_arr    o_sum,
    output t_sample_arr o_sample
);

    localparam logic [COUNT_W-1:0] CAL_LAST = COUNT_W'(CAL_SAMPLES);

    logic               r_active;
    logic               n_active;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_sum_arr           r_sum;
    t_sum_arr           n_sum;
    t_cal_status        w_status;
    logic               w_active;
    logic [COUNT_W-1:0] w_count;

    t_cal_status        r_status;
    t_sum_arr           r_sum_out;
    t_sample_arr        r_sample;

    always_comb begin
        // a request restarts the group with the clearing sample
        w_active = i_start | r_active;
        w_count  = i_start ? '0 : r_count;
        n_active = r_active;
        n_count  = r_count;
        n_sum    = r_sum;
        w_status = '0;
        if (w_active) begin
            if (w_count == '0) begin
                for (int i = 0; i < AXES; i++) begin
                    n_sum[i] = '0;
                end
                n_count      = COUNT_W'(1);
                n_active     = 1'b1;
                w_status.clr = 1'b1;
            end else begin
                for (int i = 0; i < AXES; i++) begin
                    n_sum[i] = r_sum[i] + SUM_W'(i_sample[i]);
                end
                if (w_count >= CAL_LAST) begin
                    n_count       = '0;
                    n_active      = 1'b0;
                    w_status.done = 1'b1;
                end else begin
                    n_count  = w_count + COUNT_W'(1);
                    n_active = 1'b1;
                end
            end
        end
        w_status.busy = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_count  <= '0;
            r_status <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_load) begin
            r_active <= n_active;
            r_count  <= n_count;
            r_status <= w_status;
            r_sum    <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum_out <= n_sum;
            r_sample  <= i_sample;
        end
    end

    assign o_status = r_status;
    assign o_sum    = r_sum_out;
    assign o_sample = r_sample;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAL_LAST)
        else $error("calibration count past its limit");

    a_idle_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_count == '0))
        else $error("idle group holds a nonzero count");

    a_done_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && w_status.done) |=> (!r_active && r_status.done && !r_status.busy))
        else $error("finishing transaction left the group active");
`endif

endmodule

// File: rtl/core/izoc_div.sv
// stage two: sum divided by the sample count through a reciprocal multiply
`timescale 1ns / 1ps

module izoc_div
    import izoc_pkg::*;
#(
    parameter int CAL_SAMPLES = 250
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_cal_status   i_status,
    input  t_sum_arr      i_sum,
    input  t_sample_arr   i_sample,
    output t_cal_status   o_status,
    output t_mag_arr      o_quot,
    output logic [AXES-1:0] o_neg,
    output t_sample_arr   o_sample
);

    // exact floor division for any magnitude up to 2^23
    localparam int SHIFT  = SUM_W + $clog2(CAL_SAMPLES);
    localparam int MUL_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(CAL_SAMPLES) + 64'd1;
    localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

    logic [SUM_W-1:0]  w_mag  [AXES];
    logic [PROD_W-1:0] w_prod [AXES];
    logic [AXES-1:0]   w_neg;

    t_cal_status       r_status;
    t_mag_arr          r_quot;
    logic [AXES-1:0]   r_neg;
    t_sample_arr       r_sample;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_neg[i]  = i_sum[i][SUM_W-1];
            w_mag[i]  = w_neg[i] ? $unsigned(-i_sum[i]) : $unsigned(i_sum[i]);
            w_prod[i] = {{MUL_W{1'b0}}, w_mag[i]} * {{SUM_W{1'b0}}, RECIP};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
        end else if (i_load) begin
            r_status <= i_status;
        end
    end

    // only the low 16 bits of an offset ever reach the outputs
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < AXES; i++) begin
                r_quot[i] <= w_prod[i][SHIFT +: SAMPLE_W];
            end
            r_neg    <= w_neg;
            r_sample <= i_sample;
        end
    end

    assign o_status = r_status;
    assign o_quot   = r_quot;
    assign o_neg    = r_neg;
    assign o_sample = r_sample;

endmodule

// File: rtl/core/izoc_corr.sv
// stage three: offset registers and corrected sample output register
`timescale 1ns / 1ps

module izoc_corr
    import izoc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_cal_status        i_status,
    input  t_mag_arr           i_quot,
    input  logic [AXES-1:0]    i_neg,
    input  t_sample_arr        i_sample,
    input  logic [ONE_G_W-1:0] i_z_sub,
    output t_sample_arr        o_corr,
    output logic               o_busy,
    output logic               o_done
);

    t_sample_arr r_bias;
    t_sample_arr n_bias;
    t_sample_arr w_div;
    t_sample_arr w_corr;

    t_sample_arr r_corr;
    logic        r_busy;
    logic        r_done;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_div[i] = i_neg[i] ? t_sample'(-i_quot[i]) : t_sample'(i_quot[i]);
            if (i == Z_AXIS) begin
                // gravity stays in the z reading
                w_div[i] = w_div[i] - t_sample'({1'b0, i_z_sub});
            end
            if (i_status.clr) begin
                n_bias[i] = '0;
            end else if (i_status.done) begin
                n_bias[i] = w_div[i];
            end else begin
                n_bias[i] = r_bias[i];
            end
            w_corr[i] = i_sample[i] - n_bias[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_bias[i] <= '0;
            end
        end else if (i_load) begin
            r_bias <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_corr <= w_corr;
            r_busy <= i_status.busy;
            r_done <= i_status.done;
        end
    end

    assign o_corr = r_corr;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

// File: rtl/core/imu_zero_offset_calibrator_core.sv
// Six-axis zero offset calibrator: takes one accelerometer and gyro sample per cycle and returns
// it with the stored offsets removed. Each transaction passes through registered stages (running
// sums and calibration sequencing, a reciprocal multiply per axis for the average, then offset
// update and subtraction into the output register), and a new sample is taken every cycle while
// the output side keeps up. After reset, or on a start flag, a group's first sample clears its
// offsets, the next CAL_SAMPLES samples are summed, and the sample that completes the sum
// installs the averages (accel z less one_g_counts) and is itself corrected by them. The user must write
// one_g_counts register via the cfg channel only while no sample is in flight; the block won't check.
`timescale 1ns / 1ps

module imu_zero_offset_calibrator_core
    import izoc_pkg::*;
#(
    parameter int CAL_SAMPLES = 250
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [15:0]  i_accel_x,
    input  logic signed [15:0]  i_accel_y,
    input  logic signed [15:0]  i_accel_z,
    input  logic signed [15:0]  i_rate_x,
    input  logic signed [15:0]  i_rate_y,
    input  logic signed [15:0]  i_rate_z,
    input  logic                i_start_accel_cal,
    input  logic                i_start_rate_cal,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_accel_x_corr,
    output logic signed [15:0]  o_accel_y_corr,
    output logic signed [15:0]  o_accel_z_corr,
    output logic signed [15:0]  o_rate_x_corr,
    output logic signed [15:0]  o_rate_y_corr,
    output logic signed [15:0]  o_rate_z_corr,
    output logic                o_accel_cal_busy,
    output logic                o_rate_cal_busy,
    output logic                o_accel_cal_done,
    output logic                o_rate_cal_done,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [14:0]         i_cfg_data
);

    logic               r_s1_valid;
    logic               r_s2_valid;
    logic               r_s3_valid;
    logic               w_adv1;
    logic               w_adv2;
    logic               w_adv3;
    logic               w_accept;
    logic [ONE_G_W-1:0] r_one_g;

    t_sample_arr        w_accel_in;
    t_sample_arr        w_rate_in;

    t_cal_status        w_a1_status;
    t_sum_arr           w_a1_sum;
    t_sample_arr        w_a1_sample;
    t_cal_status        w_r1_status;
    t_sum_arr           w_r1_sum;
    t_sample_arr        w_r1_sample;

    t_cal_status        w_a2_status;
    t_mag_arr           w_a2_quot;
    logic [AXES-1:0]    w_a2_neg;
    t_sample_arr        w_a2_sample;
    t_cal_status        w_r2_status;
    t_mag_arr           w_r2_quot;
    logic [AXES-1:0]    w_r2_neg;
    t_sample_arr        w_r2_sample;

    t_sample_arr        w_accel_corr;
    t_sample_arr        w_rate_corr;

    // a stage moves on when it is empty or the stage after it moves
    assign w_adv3     = !r_s3_valid || i_out_ready;
    assign w_adv2     = !r_s2_valid || w_adv3;
    assign w_adv1     = !r_s1_valid || w_adv2;
    assign o_in_ready = w_adv1;
    assign w_accept   = i_in_valid && w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_adv3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g <= ONE_G_RESET;
        end else if (i_cfg_valid) begin
            r_one_g <= i_cfg_data;
        end
    end

    assign w_accel_in[0] = i_accel_x;
    assign w_accel_in[1] = i_accel_y;
    assign w_accel_in[2] = i_accel_z;
    assign w_rate_in[0]  = i_rate_x;
    assign w_rate_in[1]  = i_rate_y;
    assign w_rate_in[2]  = i_rate_z;

    izoc_accum #(.CAL_SAMPLES(CAL_SAMPLES)) u_accel_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (w_accel_in),
        .i_start  (i_start_accel_cal),
        .o_status (w_a1_status),
        .o_sum    (w_a1_sum),
        .o_sample (w_a1_sample)
    );

    izoc_accum #(.CAL_SAMPLES(CAL_SAMPLES)) u_rate_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (w_rate_in),
        .i_start  (i_start_rate_cal),
        .o_status (w_r1_status),
        .o_sum    (w_r1_sum),
        .o_sample (w_r1_sample)
    );

    izoc_div #(.CAL_SAMPLES(CAL_SAMPLES)) u_accel_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s1_valid && w_adv2),
        .i_status (w_a1_status),
        .i_sum    (w_a1_sum),
        .i_sample (w_a1_sample),
        .o_status (w_a2_status),
        .o_quot   (w_a2_quot),
        .o_neg    (w_a2_neg),
        .o_sample (w_a2_sample)
    );

    izoc_div #(.CAL_SAMPLES(CAL_SAMPLES)) u_rate_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s1_valid && w_adv2),
        .i_status (w_r1_status),
        .i_sum    (w_r1_sum),
        .i_sample (w_r1_sample),
        .o_status (w_r2_status),
        .o_quot   (w_r2_quot),
        .o_neg    (w_r2_neg),
        .o_sample (w_r2_sample)
    );

    izoc_corr u_accel_corr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s2_valid && w_adv3),
        .i_status (w_a2_status),
        .i_quot   (w_a2_quot),
        .i_neg    (w_a2_neg),
        .i_sample (w_a2_sample),
        .i_z_sub  (r_one_g),
        .o_corr   (w_accel_corr),
        .o_busy   (o_accel_cal_busy),
        .o_done   (o_accel_cal_done)
    );

    // the gyro group has no gravity term
    izoc_corr u_rate_corr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_s2_valid && w_adv3),
        .i_status (w_r2_status),
        .i_quot   (w_r2_quot),
        .i_neg    (w_r2_neg),
        .i_sample (w_r2_sample),
        .i_z_sub  ('0),
        .o_corr   (w_rate_corr),
        .o_busy   (o_rate_cal_busy),
        .o_done   (o_rate_cal_done)
    );

    assign o_out_valid    = r_s3_valid;
    assign o_accel_x_corr = w_accel_corr[0];
    assign o_accel_y_corr = w_accel_corr[1];
    assign o_accel_z_corr = w_accel_corr[2];
    assign o_rate_x_corr  = w_rate_corr[0];
    assign o_rate_y_corr  = w_rate_corr[1];
    assign o_rate_z_corr  = w_rate_corr[2];

`ifndef NO_ASSERTIONS
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && r_s3_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transaction taken while the pipeline is full and stalled");
`endif

endmodule

// File: tb/imu_zero_offset_calibrator_core_tb.sv
// self-checking testbench for the imu zero offset calibrator core
`timescale 1ns / 1ps

module imu_zero_offset_calibrator_core_tb;
    import izoc_pkg::*;

    localparam int AVG_WINDOW   = 250;
    localparam int GAP_MAX      = 7;
    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ACC          = 0;
    localparam int GYR          = 1;

    typedef struct packed {
        t_sample [AXES-1:0] acc;
        t_sample [AXES-1:0] gyr;
        logic               start_acc;
        logic               start_gyr;
    } t_imu_in;

    typedef struct packed {
        t_sample [AXES-1:0] acc;
        t_sample [AXES-1:0] gyr;
        logic               busy_acc;
        logic               busy_gyr;
        logic               done_acc;
        logic               done_gyr;
    } t_imu_out;

    typedef struct {
        t_imu_in  stim;
        bit       typed;
        t_imu_out want;
    } t_row;

    typedef enum int {
        PH_CONTINUE,
        PH_ACCEL,
        PH_RATE,
        PH_BOTH,
        PH_RESTART,
        PH_NOISE
    } t_phase;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_imu_in             drv;
    logic                out_valid;
    logic                out_ready;
    logic signed [15:0]  out_ax, out_ay, out_az, out_rx, out_ry, out_rz;
    logic                out_busy_a, out_busy_r, out_done_a, out_done_r;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ONE_G_W-1:0]  cfg_data;

    // predictor state, one entry per sensor group
    t_sum                grp_sum    [2][AXES];
    logic signed [16:0]  grp_bias   [2][AXES];
    logic [COUNT_W-1:0]  grp_count  [2];
    bit                  grp_active [2];
    logic [ONE_G_W-1:0]  one_g;

    t_imu_out            corr_due [$];
    t_row                dir_rows [$];
    t_imu_out            seen;
    t_imu_out            head;
    int                  errors    = 0;
    int                  cycles    = 0;
    int                  sink_hold = 0;
    bit                  calm      = 1'b0;

    imu_zero_offset_calibrator_core #(
        .CAL_SAMPLES(AVG_WINDOW)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_accel_x        (drv.acc[0]),
        .i_accel_y        (drv.acc[1]),
        .i_accel_z        (drv.acc[2]),
        .i_rate_x         (drv.gyr[0]),
        .i_rate_y         (drv.gyr[1]),
        .i_rate_z         (drv.gyr[2]),
        .i_start_accel_cal(drv.start_acc),
        .i_start_rate_cal (drv.start_gyr),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_accel_x_corr   (out_ax),
        .o_accel_y_corr   (out_ay),
        .o_accel_z_corr   (out_az),
        .o_rate_x_corr    (out_rx),
        .o_rate_y_corr    (out_ry),
        .o_rate_z_corr    (out_rz),
        .o_accel_cal_busy (out_busy_a),
        .o_rate_cal_busy  (out_busy_r),
        .o_accel_cal_done (out_done_a),
        .o_rate_cal_done  (out_done_r),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // advances one group by one sample, returns 1 when new offsets are installed
    function automatic bit advance_calibration(input int g, input t_sample [AXES-1:0] smp,
                                               input bit start, input int z_sub);
        int avg;
        if (start) begin
            grp_active[g] = 1'b1;
            grp_count[g]  = '0;
        end
        if (!grp_active[g])
            return 1'b0;
        // clearing sample: offsets and sums drop to zero, nothing summed
        if (grp_count[g] == 0) begin
            for (int i = 0; i < AXES; i++) begin
                grp_sum[g][i]  = '0;
                grp_bias[g][i] = '0;
            end
            grp_count[g] = COUNT_W'(1);
            return 1'b0;
        end
        for (int i = 0; i < AXES; i++)
            grp_sum[g][i] = grp_sum[g][i] + t_sum'(smp[i]);
        if (grp_count[g] >= AVG_WINDOW) begin
            for (int i = 0; i < AXES; i++) begin
                avg = int'(grp_sum[g][i]) / AVG_WINDOW;
                if (i == Z_AXIS)
                    avg = avg - z_sub;
                grp_bias[g][i] = avg[16:0];
            end
            grp_count[g]  = '0;
            grp_active[g] = 1'b0;
            return 1'b1;
        end
        grp_count[g] = grp_count[g] + COUNT_W'(1);
        return 1'b0;
    endfunction

    function automatic t_imu_out correct_sample(input t_imu_in s);
        t_imu_out r;
        r.done_acc = advance_calibration(ACC, s.acc, s.start_acc, int'(one_g));
        r.done_gyr = advance_calibration(GYR, s.gyr, s.start_gyr, 0);
        for (int i = 0; i < AXES; i++) begin
            r.acc[i] = s.acc[i] - grp_bias[ACC][i][15:0];
            r.gyr[i] = s.gyr[i] - grp_bias[GYR][i][15:0];
        end
        r.busy_acc = grp_active[ACC];
        r.busy_gyr = grp_active[GYR];
        return r;
    endfunction

    function automatic t_imu_in mk_in(input int ax, ay, az, rx, ry, rz, input bit sa, sr);
        t_imu_in s;
        s.acc[0] = t_sample'(ax);
        s.acc[1] = t_sample'(ay);
        s.acc[2] = t_sample'(az);
        s.gyr[0] = t_sample'(rx);
        s.gyr[1] = t_sample'(ry);
        s.gyr[2] = t_sample'(rz);
        s.start_acc = sa;
        s.start_gyr = sr;
        return s;
    endfunction

    function automatic t_imu_out mk_out(input int ax, ay, az, rx, ry, rz,
                                        input bit ba, br, da, dr);
        t_imu_out r;
        r.acc[0] = t_sample'(ax);
        r.acc[1] = t_sample'(ay);
        r.acc[2] = t_sample'(az);
        r.gyr[0] = t_sample'(rx);
        r.gyr[1] = t_sample'(ry);
        r.gyr[2] = t_sample'(rz);
        r.busy_acc = ba;
        r.busy_gyr = br;
        r.done_acc = da;
        r.done_gyr = dr;
        return r;
    endfunction

    function automatic void add_row(input t_imu_in stim, input bit typed, input t_imu_out want);
        t_row row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_sample(input t_imu_in s, input bit typed, input t_imu_out want);
        int       gap;
        t_imu_out pred;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        drv      <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = correct_sample(s);
        corr_due.push_back(typed ? want : pred);
    endtask

    task automatic write_one_g(input logic [ONE_G_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (corr_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        one_g = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        if (sink_hold > 0) begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            seen.acc[0]   = out_ax;
            seen.acc[1]   = out_ay;
            seen.acc[2]   = out_az;
            seen.gyr[0]   = out_rx;
            seen.gyr[1]   = out_ry;
            seen.gyr[2]   = out_rz;
            seen.busy_acc = out_busy_a;
            seen.busy_gyr = out_busy_r;
            seen.done_acc = out_done_a;
            seen.done_gyr = out_done_r;
            if (corr_due.size() == 0) begin
                $display("%0t: result transaction with nothing outstanding", $time);
                errors++;
            end else begin
                head = corr_due.pop_front();
                check_field("accel_x_corr", head.acc[0], seen.acc[0]);
                check_field("accel_y_corr", head.acc[1], seen.acc[1]);
                check_field("accel_z_corr", head.acc[2], seen.acc[2]);
                check_field("rate_x_corr", head.gyr[0], seen.gyr[0]);
                check_field("rate_y_corr", head.gyr[1], seen.gyr[1]);
                check_field("rate_z_corr", head.gyr[2], seen.gyr[2]);
                check_field("accel_cal_busy", head.busy_acc, seen.busy_acc);
                check_field("rate_cal_busy", head.busy_gyr, seen.busy_gyr);
                check_field("accel_cal_done", head.done_acc, seen.done_acc);
                check_field("rate_cal_done", head.done_gyr, seen.done_gyr);
            end
            sink_hold <= calm ? 0 : $urandom_range(0, GAP_MAX);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_imu_out           none;
        t_imu_in            s;
        t_phase             mode;
        logic [ONE_G_W-1:0] g;
        int                 phase;
        int                 sent;
        int                 len;
        int                 restart_at;
        int                 which;
        bit                 wild;
        int                 base [2*AXES];
        int                 amp  [2*AXES];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        drv       = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < AXES; i++) begin
                grp_sum[k][i]  = '0;
                grp_bias[k][i] = '0;
            end
            grp_count[k]  = '0;
            grp_active[k] = 1'b1;
        end
        one_g = ONE_G_RESET;

        // both groups calibrate from reset, so offsets stay zero through this table
        add_row(mk_in(32767, 32767, 32767, 32767, 32767, 32767, 0, 0), 1,
                mk_out(32767, 32767, 32767, 32767, 32767, 32767, 1, 1, 0, 0));
        add_row(mk_in(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 1,
                mk_out(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 0, 0));
        add_row(mk_in(32767, -32768, 0, -1, 1, 0, 0, 0), 1,
                mk_out(32767, -32768, 0, -1, 1, 0, 1, 1, 0, 0));
        add_row(mk_in(-1, -1, -1, -1, -1, -1, 0, 0), 0, none);
        add_row(mk_in(21845, -21846, 21845, -21846, 21845, -21846, 0, 0), 0, none);
        // restart while already calibrating
        add_row(mk_in(100, -100, 4096, 7, -7, 0, 1, 0), 1,
                mk_out(100, -100, 4096, 7, -7, 0, 1, 1, 0, 0));
        add_row(mk_in(-32768, 32767, -32768, 32767, -32768, 32767, 0, 1), 1,
                mk_out(-32768, 32767, -32768, 32767, -32768, 32767, 1, 1, 0, 0));
        add_row(mk_in(1, 2, 3, 4, 5, 6, 1, 1), 1,
                mk_out(1, 2, 3, 4, 5, 6, 1, 1, 0, 0));
        add_row(mk_in(12345, -12345, 16384, -1000, 999, -2, 0, 0), 0, none);
        add_row(mk_in(0, 0, 0, 0, 0, 0, 1, 1), 1,
                mk_out(0, 0, 0, 0, 0, 0, 1, 1, 0, 0));
        add_row(mk_in(32767, 32767, 32767, 32767, 32767, 32767, 0, 0), 0, none);
        add_row(mk_in(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0), 0, none);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_one_g(15'd16384);
        foreach (dir_rows[k])
            send_sample(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

        // phases of calibration runs with biased content, plus noise and broken runs
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       g = '0;
                1:       g = '1;
                2:       g = ONE_G_RESET;
                default: g = ONE_G_W'($urandom_range(0, 16384));
            endcase
            write_one_g(g);
            mode = (phase == 0) ? PH_CONTINUE : t_phase'($urandom_range(PH_ACCEL, PH_NOISE));
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 2*AXES; k++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        base[k] = 32767;
                        amp[k]  = 0;
                    end
                    1: begin
                        base[k] = -32768;
                        amp[k]  = 0;
                    end
                    default: begin
                        base[k] = int'($urandom_range(0, 65535)) - 32768;
                        amp[k]  = $urandom_range(0, 511);
                    end
                endcase
            end
            len        = (mode == PH_NOISE) ? 60 : AVG_WINDOW + 1 + $urandom_range(0, 30);
            restart_at = $urandom_range(1, AVG_WINDOW);
            which      = $urandom_range(1, 3);
            for (int n = 0; n < len; n++) begin
                wild = (mode == PH_NOISE) || (mode == PH_RESTART && $urandom_range(0, 9) == 0);
                s = '0;
                for (int k = 0; k < AXES; k++) begin
                    s.acc[k] = wild ? t_sample'($urandom) :
                               t_sample'(base[k] + int'($urandom_range(0, amp[k])) - amp[k]/2);
                    s.gyr[k] = wild ? t_sample'($urandom) :
                               t_sample'(base[AXES+k] + int'($urandom_range(0, amp[AXES+k]))
                                         - amp[AXES+k]/2);
                end
                case (mode)
                    PH_ACCEL: s.start_acc = (n == 0);
                    PH_RATE:  s.start_gyr = (n == 0);
                    PH_BOTH: begin
                        s.start_acc = (n == 0);
                        s.start_gyr = (n == 0);
                    end
                    PH_RESTART: begin
                        s.start_acc = (n == 0) || (n == restart_at && which[0]);
                        s.start_gyr = (n == 0) || (n == restart_at && which[1]);
                    end
                    PH_NOISE: begin
                        s.start_acc = ($urandom_range(0, 15) == 0);
                        s.start_gyr = ($urandom_range(0, 15) == 0);
                    end
                    default: ;
                endcase
                send_sample(s, 1'b0, none);
                sent++;
            end
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (corr_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
